// ----- rtl/krlt_pkg.sv -----
`timescale 1ns / 1ps
// krlt_pkg: field widths, slot layout, status codes and controller states
// for the keyed rate limit table; no dependencies
package krlt_pkg;

    localparam int KEY_W  = 32;
    localparam int LINE_W = 16;
    localparam int WIN_W  = 16;
    localparam int LIM_W  = 16;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 17;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // key reduction works on one byte of the key per cycle
    localparam int HASH_DIGIT_W = 8;
    localparam int HASH_DIGITS  = KEY_W / HASH_DIGIT_W;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [LINE_W-1:0] line;
        logic [WIN_W-1:0]  window;
        logic [LIM_W-1:0]  limit;
        logic [TIME_W-1:0] window_start;
        logic [CNT_W-1:0]  count;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [STAT_W-1:0] {
        ST_HIT_OK   = 3'd0,
        ST_HIT_OVER = 3'd1,
        ST_INVALID  = 3'd2,
        ST_NEW      = 3'd3,
        ST_REC_FAIL = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_HIT,
        S_EMIT
    } t_state;

endpackage

// ----- rtl/krlt_req_if.sv -----
`timescale 1ns / 1ps
// krlt_req_if: request channel, valid/ready plus request fields
// depends on krlt_pkg for widths
interface krlt_req_if;
    logic                         valid;
    logic                         ready;
    logic [krlt_pkg::KEY_W-1:0]   key;
    logic [krlt_pkg::LINE_W-1:0]  line_no;
    logic [krlt_pkg::WIN_W-1:0]   window_seconds;
    logic [krlt_pkg::LIM_W-1:0]   max_count;
    logic [krlt_pkg::TIME_W-1:0]  now_seconds;

    modport source (output valid, key, line_no, window_seconds, max_count, now_seconds,
                    input ready);
    modport sink   (input valid, key, line_no, window_seconds, max_count, now_seconds,
                    output ready);
endinterface

// ----- rtl/krlt_res_if.sv -----
`timescale 1ns / 1ps
// krlt_res_if: result channel, valid/ready plus allow and status
// depends on krlt_pkg for widths
interface krlt_res_if;
    logic                         valid;
    logic                         ready;
    logic                         allow;
    logic [krlt_pkg::STAT_W-1:0]  status;

    modport source (output valid, allow, status, input ready);
    modport sink   (input valid, allow, status, output ready);
endinterface

// ----- rtl/keyed_rate_limit_table_unit.sv -----
`timescale 1ns / 1ps
// keyed_rate_limit_table_unit: per (key, line) fixed-window rate limiter on an
// open-addressed table; depends on krlt_pkg, krlt_req_if, krlt_res_if,
// krlt_ram and krlt_hash
//
// usage:
//   i_req carries one request per transaction (key, line_no, window_seconds,
//   max_count, now_seconds); o_res returns exactly one transaction per request
//   (allow, status), in request order.
//   one request is handled at a time. a request with a zero key or line
//   reaches the result register in the cycle after acceptance. any other
//   request reduces the key modulo TABLE_DEPTH (one key byte per cycle,
//   then a hand-over of the slot index), reads the first table slot, then
//   examines one probed slot of the table ram per cycle, updates the entry
//   on a hit, and loads the result.
//   the probe walk ends at the matching slot or the first empty slot; at
//   most TABLE_DEPTH slots are probed.
//   after reset the table ram is cleared one slot per cycle, with i_req.ready
//   low.
//   the result sits in an output register; a new request is accepted while it
//   waits, and a later result waits in the controller until it is taken.
module keyed_rate_limit_table_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    krlt_req_if.sink    i_req,
    krlt_res_if.source  o_res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    krlt_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_probe, n_probe;

    logic [krlt_pkg::KEY_W-1:0]  r_key;
    logic [krlt_pkg::LINE_W-1:0] r_line;
    logic [krlt_pkg::WIN_W-1:0]  r_win;
    logic [krlt_pkg::LIM_W-1:0]  r_lim;
    logic [krlt_pkg::TIME_W-1:0] r_now;
    krlt_pkg::t_slot             r_slot, n_slot;

    logic              r_res_allow, n_res_allow;
    krlt_pkg::t_status r_res_status, n_res_status;

    logic              r_out_valid, n_out_valid;
    logic              r_out_allow, n_out_allow;
    krlt_pkg::t_status r_out_status, n_out_status;

    logic            req_take;
    logic            req_bad;
    logic            hash_start;
    logic            hash_done;
    logic [IDX_W-1:0] hash_rem;
    logic [IDX_W-1:0] idx_next;

    logic            ram_we;
    logic [IDX_W-1:0] ram_waddr;
    krlt_pkg::t_slot ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    krlt_pkg::t_slot ram_rdata;

    logic                        slot_match;
    logic                        slot_empty;
    logic [krlt_pkg::TIME_W-1:0] elapsed;
    logic                        restart;
    logic [krlt_pkg::CNT_W-1:0]  cnt_eff;
    logic                        hit_ok;

    krlt_ram #(
        .WIDTH (krlt_pkg::SLOT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    krlt_hash #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_req.key),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    assign i_req.ready = (r_state == krlt_pkg::S_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign req_bad     = (i_req.key == '0) || (i_req.line_no == '0);
    assign hash_start  = req_take && !req_bad;
    assign idx_next    = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;

    assign slot_match = (ram_rdata.key == r_key) && (ram_rdata.line == r_line);
    assign slot_empty = (ram_rdata.key == '0);

    // fixed window on the latched hit entry
    assign elapsed = r_now - r_slot.window_start;
    assign restart = elapsed > krlt_pkg::TIME_W'(r_slot.window);
    assign cnt_eff = restart ? '0 : r_slot.count;
    assign hit_ok  = cnt_eff < krlt_pkg::CNT_W'(r_slot.limit);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_probe      = r_probe;
        n_slot       = r_slot;
        n_res_allow  = r_res_allow;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_allow  = r_out_allow;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = '0;
        ram_raddr    = r_idx;

        unique case (r_state)
            krlt_pkg::S_CLEAR: begin
                ram_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = krlt_pkg::S_IDLE;
                end
            end
            krlt_pkg::S_IDLE: begin
                if (req_take) begin
                    if (req_bad) begin
                        n_res_allow  = 1'b0;
                        n_res_status = krlt_pkg::ST_INVALID;
                        n_state      = krlt_pkg::S_EMIT;
                    end else begin
                        n_state = krlt_pkg::S_HASH;
                    end
                end
            end
            krlt_pkg::S_HASH: begin
                if (hash_done) begin
                    n_idx   = hash_rem;
                    n_probe = '0;
                    n_state = krlt_pkg::S_READ;
                end
            end
            krlt_pkg::S_READ: begin
                n_state = krlt_pkg::S_CHECK;
            end
            krlt_pkg::S_CHECK: begin
                // next slot is read ahead while this one is examined
                ram_raddr = idx_next;
                if (slot_match) begin
                    n_slot  = ram_rdata;
                    n_state = krlt_pkg::S_HIT;
                end else if (slot_empty) begin
                    if (r_win != '0 && r_lim != '0) begin
                        ram_we                 = 1'b1;
                        ram_wdata.key          = r_key;
                        ram_wdata.line         = r_line;
                        ram_wdata.window       = r_win;
                        ram_wdata.limit        = r_lim;
                        ram_wdata.window_start = r_now;
                        ram_wdata.count        = krlt_pkg::CNT_W'(1);
                        n_res_status           = krlt_pkg::ST_NEW;
                    end else begin
                        n_res_status = krlt_pkg::ST_REC_FAIL;
                    end
                    n_res_allow = 1'b1;
                    n_state     = krlt_pkg::S_EMIT;
                end else if (r_probe == IDX_LAST) begin
                    n_res_allow  = 1'b1;
                    n_res_status = krlt_pkg::ST_REC_FAIL;
                    n_state      = krlt_pkg::S_EMIT;
                end else begin
                    n_idx   = idx_next;
                    n_probe = r_probe + 1'b1;
                end
            end
            krlt_pkg::S_HIT: begin
                ram_we    = 1'b1;
                ram_wdata = r_slot;
                if (restart) begin
                    ram_wdata.window_start = r_now;
                end
                ram_wdata.count = (cnt_eff == krlt_pkg::COUNT_MAX) ? cnt_eff
                                                                   : cnt_eff + 1'b1;
                n_res_allow  = hit_ok;
                n_res_status = hit_ok ? krlt_pkg::ST_HIT_OK : krlt_pkg::ST_HIT_OVER;
                n_state      = krlt_pkg::S_EMIT;
            end
            krlt_pkg::S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_allow  = r_res_allow;
                    n_out_status = r_res_status;
                    n_state      = krlt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = krlt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= krlt_pkg::S_CLEAR;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_key  <= i_req.key;
            r_line <= i_req.line_no;
            r_win  <= i_req.window_seconds;
            r_lim  <= i_req.max_count;
            r_now  <= i_req.now_seconds;
        end
        r_probe      <= n_probe;
        r_slot       <= n_slot;
        r_res_allow  <= n_res_allow;
        r_res_status <= n_res_status;
        r_out_allow  <= n_out_allow;
        r_out_status <= n_out_status;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.allow  = r_out_allow;
    assign o_res.status = r_out_status;

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krlt_pkg::S_IDLE || r_state == krlt_pkg::S_EMIT) |-> !ram_we)
        else $error("table written outside clear, insert or update");

    a_bad_req_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && req_bad) |=> (r_state == krlt_pkg::S_EMIT && !r_res_allow))
        else $error("invalid key or line not denied at once");

    a_hit_entry_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == krlt_pkg::S_HIT) |-> (r_slot.key == r_key && r_slot.line == r_line))
        else $error("hit update on a slot of another key");

    a_hash_in_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == krlt_pkg::S_HASH))
        else $error("key reduction finished outside its state");
`endif

endmodule

// ----- rtl/krlt_ram.sv -----
`timescale 1ns / 1ps
// krlt_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
module krlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/krlt_hash.sv -----
`timescale 1ns / 1ps
// krlt_hash: key modulo table depth, one key byte per cycle (shift-subtract)
// depends on krlt_pkg
module krlt_hash #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [krlt_pkg::KEY_W-1:0]     i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rem
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int DCNT_W  = $clog2(krlt_pkg::HASH_DIGITS);
    localparam logic [IDX_W:0]    DEPTH_V    = (IDX_W + 1)'(TABLE_DEPTH);
    localparam logic [DCNT_W-1:0] DIGIT_LAST = DCNT_W'(krlt_pkg::HASH_DIGITS - 1);

    logic                         r_busy;
    logic                         r_done;
    logic [DCNT_W-1:0]            r_cnt;
    logic [krlt_pkg::KEY_W-1:0]   r_key;
    logic [IDX_W-1:0]             r_rem;
    logic [IDX_W-1:0]             n_rem;

    always_comb begin
        logic [IDX_W:0] v;
        v = {1'b0, r_rem};
        for (int b = 0; b < krlt_pkg::HASH_DIGIT_W; b++) begin
            v = {v[IDX_W-1:0], r_key[krlt_pkg::KEY_W-1-b]};
            if (v >= DEPTH_V) begin
                v = v - DEPTH_V;
            end
        end
        n_rem = v[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIGIT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
            r_rem <= '0;
        end else if (r_busy) begin
            r_key <= r_key << krlt_pkg::HASH_DIGIT_W;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for keyed_rate_limit_table_unit, table-driven directed rows
// then random requests; depends on krlt_pkg, krlt_req_if, krlt_res_if
module tb_top;

    localparam int TABLE_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 700;
    localparam int STUCK_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 64;
    localparam int POOL_CAP      = 64;

    typedef struct packed {
        logic [krlt_pkg::KEY_W-1:0]  key;
        logic [krlt_pkg::LINE_W-1:0] line_no;
        logic [krlt_pkg::WIN_W-1:0]  window_seconds;
        logic [krlt_pkg::LIM_W-1:0]  max_count;
        logic [krlt_pkg::TIME_W-1:0] now_seconds;
    } t_request;

    typedef struct packed {
        logic              allow;
        krlt_pkg::t_status status;
    } t_verdict;

    typedef struct packed {
        bit       typed;
        t_verdict want;
        t_request rq;
    } t_row;

    typedef struct packed {
        logic [krlt_pkg::KEY_W-1:0]  key;
        logic [krlt_pkg::LINE_W-1:0] line_no;
    } t_pair;

    logic clk;
    logic rst_n;
    bit   steady;
    int   sink_stall;
    int   stuck_cycles;
    int   fault_count;

    krlt_req_if req_ch ();
    krlt_res_if res_ch ();

    keyed_rate_limit_table_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    // limiter shadow state
    bit [krlt_pkg::KEY_W-1:0]  tbl_key    [TABLE_DEPTH];
    bit [krlt_pkg::LINE_W-1:0] tbl_line   [TABLE_DEPTH];
    bit [krlt_pkg::WIN_W-1:0]  tbl_span   [TABLE_DEPTH];
    bit [krlt_pkg::LIM_W-1:0]  tbl_quota  [TABLE_DEPTH];
    bit [krlt_pkg::TIME_W-1:0] tbl_opened [TABLE_DEPTH];
    bit [krlt_pkg::CNT_W-1:0]  tbl_hits   [TABLE_DEPTH];
    int                        tbl_fill;

    t_verdict                    awaited_verdicts [$];
    t_pair                       known_pairs [$];
    logic [krlt_pkg::TIME_W-1:0] wall_clock;

    t_row directed_rows [23] = '{
        '{1'b1, '{1'b0, krlt_pkg::ST_INVALID},
              '{32'd0, 16'd5, 16'd10, 16'd3, 32'd0}},
        '{1'b1, '{1'b0, krlt_pkg::ST_INVALID},
              '{32'd7, 16'd0, 16'd10, 16'd3, 32'd0}},
        '{1'b1, '{1'b0, krlt_pkg::ST_INVALID},
              '{32'd0, 16'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}},
        '{1'b1, '{1'b1, krlt_pkg::ST_REC_FAIL},
              '{32'd5, 16'd1, 16'd0, 16'd3, 32'd100}},
        '{1'b1, '{1'b1, krlt_pkg::ST_REC_FAIL},
              '{32'd5, 16'd1, 16'd10, 16'd0, 32'd100}},
        '{1'b1, '{1'b1, krlt_pkg::ST_NEW},
              '{32'd5, 16'd1, 16'd10, 16'd2, 32'd100}},
        '{1'b1, '{1'b1, krlt_pkg::ST_HIT_OK},
              '{32'd5, 16'd1, 16'd10, 16'd2, 32'd105}},
        '{1'b1, '{1'b0, krlt_pkg::ST_HIT_OVER},
              '{32'd5, 16'd1, 16'd10, 16'd2, 32'd110}},
        '{1'b1, '{1'b1, krlt_pkg::ST_HIT_OK},
              '{32'd5, 16'd1, 16'd10, 16'd2, 32'd111}},
        '{1'b1, '{1'b1, krlt_pkg::ST_NEW},
              '{32'd5, 16'd2, 16'd1, 16'd1, 32'd0}},
        '{1'b1, '{1'b1, krlt_pkg::ST_NEW},
              '{32'd1029, 16'd1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0}},
        '{1'b1, '{1'b1, krlt_pkg::ST_NEW},
              '{32'd6, 16'd9, 16'd3, 16'd1, 32'd0}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'd1029, 16'd1, 16'd0, 16'd0, 32'd5}},
        '{1'b1, '{1'b1, krlt_pkg::ST_NEW},
              '{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF}},
        '{1'b1, '{1'b1, krlt_pkg::ST_NEW},
              '{32'h400, 16'd1, 16'd1, 16'd1, 32'd0}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'h7FF, 16'd3, 16'd2, 16'd2, 32'd0}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'h7FF, 16'd3, 16'd2, 16'd2, 32'd1}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'd5, 16'd1, 16'd0, 16'd0, 32'd121}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'hFFFF_FFFF, 16'hFFFF, 16'd1, 16'd1, 32'd0}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'h400, 16'd1, 16'd1, 16'd1, 32'hFFFF_FFFF}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'h400, 16'd1, 16'd1, 16'd1, 32'hFFFF_FFFF}},
        '{1'b1, '{1'b1, krlt_pkg::ST_REC_FAIL},
              '{32'd5, 16'd3, 16'd0, 16'd5, 32'd200}},
        '{1'b0, '{1'b0, krlt_pkg::ST_HIT_OK},
              '{32'd6, 16'd9, 16'd3, 16'd1, 32'hFFFF_0000}}
    };

    function automatic t_verdict limiter_verdict(t_request rq);
        int unsigned               home;
        int unsigned               idx;
        bit [krlt_pkg::TIME_W-1:0] elapsed;
        bit                        pass;
        home = rq.key % TABLE_DEPTH;
        if (rq.key == '0 || rq.line_no == '0) begin
            return '{allow: 1'b0, status: krlt_pkg::ST_INVALID};
        end
        if (tbl_fill > 0) begin
            idx = home;
            repeat (TABLE_DEPTH) begin
                if (tbl_key[idx] == rq.key && tbl_line[idx] == rq.line_no) begin
                    elapsed = rq.now_seconds - tbl_opened[idx];
                    if (elapsed > krlt_pkg::TIME_W'(tbl_span[idx])) begin
                        tbl_opened[idx] = rq.now_seconds;
                        tbl_hits[idx]   = '0;
                    end
                    pass = tbl_hits[idx] < krlt_pkg::CNT_W'(tbl_quota[idx]);
                    if (tbl_hits[idx] != krlt_pkg::COUNT_MAX) begin
                        tbl_hits[idx] = tbl_hits[idx] + 1'b1;
                    end
                    return '{allow: pass,
                             status: pass ? krlt_pkg::ST_HIT_OK : krlt_pkg::ST_HIT_OVER};
                end
                idx = (idx + 1) % TABLE_DEPTH;
            end
        end
        if (rq.window_seconds != '0 && rq.max_count != '0 && tbl_fill < TABLE_DEPTH) begin
            idx = home;
            repeat (TABLE_DEPTH) begin
                if (tbl_key[idx] == '0) begin
                    tbl_key[idx]    = rq.key;
                    tbl_line[idx]   = rq.line_no;
                    tbl_span[idx]   = rq.window_seconds;
                    tbl_quota[idx]  = rq.max_count;
                    tbl_opened[idx] = rq.now_seconds;
                    tbl_hits[idx]   = krlt_pkg::CNT_W'(1);
                    tbl_fill++;
                    return '{allow: 1'b1, status: krlt_pkg::ST_NEW};
                end
                idx = (idx + 1) % TABLE_DEPTH;
            end
        end
        return '{allow: 1'b1, status: krlt_pkg::ST_REC_FAIL};
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (steady || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    function automatic logic [15:0] pick_field(int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(lo, hi));
        if (r < 88) return 16'd0;
        if (r < 94) return 16'hFFFF;
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic t_request random_request();
        t_request rq;
        t_pair    p;
        int       pick;
        int       how;
        pick = $urandom_range(0, 99);
        wall_clock = wall_clock + $urandom_range(0, 4);
        if ($urandom_range(0, 49) == 0) wall_clock = $urandom;
        rq.now_seconds    = wall_clock;
        rq.window_seconds = pick_field(1, 20);
        rq.max_count      = pick_field(1, 6);
        if (pick < 60 && known_pairs.size() != 0) begin
            p = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
            rq.key     = p.key;
            rq.line_no = p.line_no;
        end else if (pick < 82) begin
            how = (known_pairs.size() == 0) ? 0 : $urandom_range(0, 3);
            if (how != 0) p = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
            case (how)
                0: rq.key = $urandom;
                1: rq.key = p.key + TABLE_DEPTH * $urandom_range(1, 7);
                2: rq.key = p.key + $urandom_range(1, 3);
                default: rq.key = p.key;
            endcase
            rq.line_no = 16'($urandom_range(1, 16'hFFFF));
            if (rq.key != '0) begin
                if (known_pairs.size() >= POOL_CAP)
                    known_pairs.delete($urandom_range(0, known_pairs.size() - 1));
                known_pairs.push_back('{rq.key, rq.line_no});
            end
        end else if (pick < 92) begin
            how = $urandom_range(0, 2);
            rq.key     = (how == 1) ? krlt_pkg::KEY_W'($urandom) : '0;
            rq.line_no = (how == 0) ? krlt_pkg::LINE_W'($urandom) : '0;
        end else begin
            rq.key            = $urandom;
            rq.line_no        = krlt_pkg::LINE_W'($urandom);
            rq.window_seconds = krlt_pkg::WIN_W'($urandom);
            rq.max_count      = krlt_pkg::LIM_W'($urandom);
            rq.now_seconds    = $urandom;
        end
        return rq;
    endfunction

    task automatic offer(input t_request rq, input bit typed, input t_verdict want);
        t_verdict v;
        req_ch.valid          <= 1'b1;
        req_ch.key            <= rq.key;
        req_ch.line_no        <= rq.line_no;
        req_ch.window_seconds <= rq.window_seconds;
        req_ch.max_count      <= rq.max_count;
        req_ch.now_seconds    <= rq.now_seconds;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        v = limiter_verdict(rq);
        awaited_verdicts.push_back(typed ? want : v);
    endtask

    task automatic pause_after(input int cycles);
        if (cycles != 0) begin
            req_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result sink with random back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            sink_stall   <= 0;
        end else if (sink_stall != 0) begin
            res_ch.ready <= 1'b0;
            sink_stall   <= sink_stall - 1;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            res_ch.ready <= 1'b0;
            sink_stall   <= idle_len() - 1;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_check
        t_verdict want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (awaited_verdicts.size() == 0) begin
                fault_count++;
                $display("%0t ns: result with nothing outstanding, expected none, %s",
                         $time, "actual below");
                $display("%0t ns: actual allow %0b status %0d",
                         $time, res_ch.allow, res_ch.status);
            end else begin
                want = awaited_verdicts.pop_front();
                if (res_ch.allow !== want.allow) begin
                    fault_count++;
                    $display("%0t ns: allow expected %0b actual %0b",
                             $time, want.allow, res_ch.allow);
                end
                if (res_ch.status !== want.status) begin
                    fault_count++;
                    $display("%0t ns: status expected %0d actual %0d",
                             $time, want.status, res_ch.status);
                end
            end
        end
    end

    // watchdog on transaction progress
    always @(posedge clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        t_verdict none;
        int       n;
        none                  = '{allow: 1'b0, status: krlt_pkg::ST_HIT_OK};
        rst_n                 = 1'b0;
        steady                = 1'b0;
        stuck_cycles          = 0;
        fault_count           = 0;
        tbl_fill              = 0;
        wall_clock            = 32'hFFFF_FF80;
        req_ch.valid          = 1'b0;
        req_ch.key            = '0;
        req_ch.line_no        = '0;
        req_ch.window_seconds = '0;
        req_ch.max_count      = '0;
        req_ch.now_seconds    = '0;
        res_ch.ready          = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
            pause_after(sender_gap());
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            offer(random_request(), 1'b0, none);
            if (n % 97 == 96) drain();
            else pause_after(sender_gap());
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
